FILE: rtl/core/ust_pkg.sv
// Shared encoding codes, register indexes and result types of the UTF stream transcoder.
`default_nettype none

package ust_pkg;

    localparam logic [2:0] ENC_UTF8    = 3'd0;
    localparam logic [2:0] ENC_UTF16LE = 3'd1;
    localparam logic [2:0] ENC_UTF16BE = 3'd2;
    localparam logic [2:0] ENC_UTF32LE = 3'd3;
    localparam logic [2:0] ENC_UTF32BE = 3'd4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ENCODING      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ENCODING      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_CODEPOINT = 2'd2;

    localparam logic [20:0] REPLACEMENT_RESET = 21'h00FFFD;

    typedef struct packed {
        logic        ok;
        logic [20:0] cp;
    } decode_result_t;

    typedef struct packed {
        logic [2:0]  count;
        logic [31:0] bytes;
    } encode_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/utf_stream_transcoder.sv
// Top level of the UTF stream transcoder: group gathering, decode, re-encode and byte serializer.
`default_nettype none

// Source bytes enter on s_axis at up to one per cycle; tlast marks the last byte of
// the stream. A byte that completes a code unit group is held in a group register,
// decoded and re-encoded into an output shift register, which sends 1 to 4 target bytes
// on m_axis, one per cycle while m_axis_tready is high. A completed group waits in the
// group register while the output shift register holds more than its final byte, or
// holds its final byte and m_axis_tready is low; input stalls only while such a group
// waits, so the sustained rate is one source byte per cycle, or one output byte per
// cycle when a group expands into more bytes than it arrived with. m_axis_tlast marks
// the last byte of one input item; tuser[0] marks the final item of the stream and
// tuser[1] an error item (stream ended inside a group or on a dropped stray byte). The
// user must write registers only while the block is idle; the block does not enforce
// this. Writing source_encoding drops any open group. Encoding codes 5 to 7 act as
// UTF-8.
module utf_stream_transcoder
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [ust_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ust_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,   // in_byte
    input  wire logic                              s_axis_tlast,   // stream_end

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [7:0]                             m_axis_tdata,   // out_byte
    output logic                                   m_axis_tlast,   // unit_last
    output logic [1:0]                             m_axis_tuser    // stream_done, stream_error
);

    logic [2:0]  source_encoding_reg;
    logic [2:0]  target_encoding_reg;
    logic [20:0] replacement_reg;

    logic [7:0]  gb_reg [3];
    logic [7:0]  gb_next [3];
    logic [1:0]  held_reg, held_next;
    logic [2:0]  glen_reg, glen_next;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_err_reg, s1_err_next;
    logic        s1_end_reg, s1_end_next;
    logic [31:0] s1_g_reg, s1_g_next;
    logic [2:0]  s1_len_reg, s1_len_next;

    logic [31:0] ob_reg, ob_next;
    logic [2:0]  ocnt_reg, ocnt_next;
    logic        oend_reg, oend_next;
    logic        oerr_reg, oerr_next;

    logic        in_accept;
    logic        out_take;
    logic        s1_move;
    logic [2:0]  src;
    logic [2:0]  tgt;
    logic [2:0]  lead_len;
    logic [2:0]  glen_eff;
    logic [7:0]  utf16_lead;
    logic        complete;

    ust_pkg::decode_result_t dec;
    ust_pkg::encode_result_t enc;
    logic [20:0] cp_sel;

    function automatic logic [2:0] norm_enc(input logic [2:0] e);
        return (e > ust_pkg::ENC_UTF32BE) ? ust_pkg::ENC_UTF8 : e;
    endfunction

    function automatic ust_pkg::decode_result_t decode_group(
        input logic [31:0] g,
        input logic [2:0]  len,
        input logic [2:0]  enc_code
    );
        ust_pkg::decode_result_t r;
        logic        ok;
        logic [31:0] v;
        logic [7:0]  g0, g1, g2, g3;
        logic [7:0]  u0, u1, u2, u3;
        logic [7:0]  bi;
        g0 = g[7:0];
        g1 = g[15:8];
        g2 = g[23:16];
        g3 = g[31:24];
        ok = 1'b1;
        v  = '0;
        if (enc_code == ust_pkg::ENC_UTF8)
        begin
            for (int i = 0; i < 4; i++)
            begin
                bi = g[8*i +: 8];
                if ((3'(i) < len) && (bi == 8'hFF || bi == 8'hFE || bi[7:1] == 7'b1100000))
                begin
                    ok = 1'b0;
                end
            end
            case (len)
                3'd1:
                begin
                    if (g0[7])
                    begin
                        ok = 1'b0;
                    end
                    v = {24'b0, g0};
                end
                3'd2:
                begin
                    if (g0 < 8'hC2 || g0 > 8'hF7 || g0[7:5] != 3'b110 || g1[7:6] != 2'b10)
                    begin
                        ok = 1'b0;
                    end
                    v = {21'b0, g0[4:0], g1[5:0]};
                end
                3'd3:
                begin
                    if (g0 < 8'hC2 || g0 > 8'hF7 || g0[7:4] != 4'b1110 ||
                        g1[7:6] != 2'b10 || g2[7:6] != 2'b10)
                    begin
                        ok = 1'b0;
                    end
                    v = {16'b0, g0[3:0], g1[5:0], g2[5:0]};
                    if (v < 32'h800)
                    begin
                        ok = 1'b0;
                    end
                end
                3'd4:
                begin
                    if (g0 < 8'hC2 || g0 > 8'hF7 || g0[7:3] != 5'b11110 ||
                        g1[7:6] != 2'b10 || g2[7:6] != 2'b10 || g3[7:6] != 2'b10)
                    begin
                        ok = 1'b0;
                    end
                    v = {11'b0, g0[2:0], g1[5:0], g2[5:0], g3[5:0]};
                    if (v < 32'h10000)
                    begin
                        ok = 1'b0;
                    end
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
        else if (enc_code == ust_pkg::ENC_UTF16LE || enc_code == ust_pkg::ENC_UTF16BE)
        begin
            if (enc_code == ust_pkg::ENC_UTF16BE)
            begin
                u0 = g0;
                u1 = g1;
                u2 = g2;
                u3 = g3;
            end
            else
            begin
                u0 = g1;
                u1 = g0;
                u2 = g3;
                u3 = g2;
            end
            if (len == 3'd2)
            begin
                if (u0[7:3] == 5'b11011)
                begin
                    ok = 1'b0;
                end
                v = {16'b0, u0, u1};
            end
            else
            begin
                if (u0[7:2] != 6'b110110 || u2[7:2] != 6'b110111)
                begin
                    ok = 1'b0;
                end
                v = 32'h10000 + {12'b0, u0[1:0], u1, u2[1:0], u3};
            end
        end
        else if (enc_code == ust_pkg::ENC_UTF32BE)
        begin
            v = {g0, g1, g2, g3};
        end
        else
        begin
            v = {g3, g2, g1, g0};
        end
        if (v > 32'h10FFFF || (v >= 32'hD800 && v <= 32'hDFFF))
        begin
            ok = 1'b0;
        end
        r.ok = ok;
        r.cp = v[20:0];
        return r;
    endfunction

    function automatic ust_pkg::encode_result_t encode_cp(
        input logic [20:0] cp,
        input logic [2:0]  enc_code
    );
        ust_pkg::encode_result_t r;
        logic [19:0] off;
        logic [15:0] hi;
        logic [15:0] lo;
        off = 20'(cp - 21'h10000);
        hi  = '0;
        lo  = '0;
        r.bytes = '0;
        r.count = 3'd4;
        if (enc_code == ust_pkg::ENC_UTF8)
        begin
            if (cp < 21'h80)
            begin
                r.bytes = {24'b0, 1'b0, cp[6:0]};
                r.count = 3'd1;
            end
            else if (cp < 21'h800)
            begin
                r.bytes = {16'b0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
                r.count = 3'd2;
            end
            else if (cp < 21'h10000)
            begin
                r.bytes = {8'b0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
                r.count = 3'd3;
            end
            else
            begin
                r.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                           5'b11110, cp[20:18]};
                r.count = 3'd4;
            end
        end
        else if (enc_code == ust_pkg::ENC_UTF16LE || enc_code == ust_pkg::ENC_UTF16BE)
        begin
            if (cp < 21'h10000)
            begin
                hi = cp[15:0];
                lo = '0;
                r.count = 3'd2;
            end
            else
            begin
                hi = {6'b110110, off[19:10]};
                lo = {6'b110111, off[9:0]};
                r.count = 3'd4;
            end
            if (enc_code == ust_pkg::ENC_UTF16BE)
            begin
                r.bytes = {lo[7:0], lo[15:8], hi[7:0], hi[15:8]};
            end
            else
            begin
                r.bytes = {lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
            end
        end
        else if (enc_code == ust_pkg::ENC_UTF32BE)
        begin
            r.bytes = {cp[7:0], cp[15:8], 3'b0, cp[20:16], 8'b0};
        end
        else
        begin
            r.bytes = {8'b0, 3'b0, cp[20:16], cp[15:8], cp[7:0]};
        end
        return r;
    endfunction

    assign src = norm_enc(source_encoding_reg);
    assign tgt = norm_enc(target_encoding_reg);

    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign s1_move       = s1_valid_reg && ((ocnt_reg == 3'd0) ||
                                            (ocnt_reg == 3'd1 && m_axis_tready));
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (src != ust_pkg::ENC_UTF8)
        begin
            lead_len = (src <= ust_pkg::ENC_UTF16BE) ? 3'd2 : 3'd4;
        end
        else if (s_axis_tdata[7:6] == 2'b10)
        begin
            lead_len = 3'd0;
        end
        else if (!s_axis_tdata[7])
        begin
            lead_len = 3'd1;
        end
        else if (s_axis_tdata[7:5] == 3'b110)
        begin
            lead_len = 3'd2;
        end
        else if (s_axis_tdata[7:4] == 4'b1110)
        begin
            lead_len = 3'd3;
        end
        else
        begin
            lead_len = 3'd4;
        end
    end

    always_comb
    begin
        utf16_lead = (src == ust_pkg::ENC_UTF16BE) ? gb_reg[0] : s_axis_tdata;
        glen_eff   = glen_reg;
        if ((src == ust_pkg::ENC_UTF16LE || src == ust_pkg::ENC_UTF16BE) &&
            glen_reg == 3'd2 && held_reg == 2'd1 && utf16_lead[7:2] == 6'b110110)
        begin
            glen_eff = 3'd4;
        end
    end

    always_comb
    begin
        gb_next       = gb_reg;
        held_next     = held_reg;
        glen_next     = glen_reg;
        s1_valid_next = s1_valid_reg;
        s1_err_next   = s1_err_reg;
        s1_end_next   = s1_end_reg;
        s1_g_next     = s1_g_reg;
        s1_len_next   = s1_len_reg;
        complete      = 1'b0;

        if (in_accept)
        begin
            s1_g_next   = '0;
            s1_len_next = '0;
            if (glen_reg == 3'd0)
            begin
                if (lead_len == 3'd1)
                begin
                    s1_g_next   = {24'b0, s_axis_tdata};
                    s1_len_next = 3'd1;
                    complete    = 1'b1;
                end
                else if (lead_len > 3'd1)
                begin
                    gb_next[0] = s_axis_tdata;
                    held_next  = 2'd1;
                    glen_next  = lead_len;
                end
            end
            else if ((({1'b0, held_reg} + 3'd1) >= glen_eff) || held_reg == 2'd3)
            begin
                complete    = 1'b1;
                s1_len_next = {1'b0, held_reg} + 3'd1;
                case (held_reg)
                    2'd0:    s1_g_next = {24'b0, s_axis_tdata};
                    2'd1:    s1_g_next = {16'b0, s_axis_tdata, gb_reg[0]};
                    2'd2:    s1_g_next = {8'b0, s_axis_tdata, gb_reg[1], gb_reg[0]};
                    default: s1_g_next = {s_axis_tdata, gb_reg[2], gb_reg[1], gb_reg[0]};
                endcase
                gb_next   = '{default: 8'h00};
                held_next = 2'd0;
                glen_next = 3'd0;
            end
            else
            begin
                gb_next[held_reg] = s_axis_tdata;
                held_next         = held_reg + 2'd1;
                glen_next         = glen_eff;
            end

            if (!complete && s_axis_tlast)
            begin
                gb_next   = '{default: 8'h00};
                held_next = 2'd0;
                glen_next = 3'd0;
            end
            s1_valid_next = complete || s_axis_tlast;
            s1_err_next   = !complete;
            s1_end_next   = s_axis_tlast;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        if (cfg_we && cfg_index == ust_pkg::CFG_SOURCE_ENCODING)
        begin
            gb_next   = '{default: 8'h00};
            held_next = 2'd0;
            glen_next = 3'd0;
        end
    end

    assign dec    = decode_group(s1_g_reg, s1_len_reg, src);
    assign cp_sel = dec.ok ? dec.cp : replacement_reg;
    assign enc    = encode_cp(cp_sel, tgt);

    always_comb
    begin
        ob_next   = ob_reg;
        ocnt_next = ocnt_reg;
        oend_next = oend_reg;
        oerr_next = oerr_reg;
        if (s1_move)
        begin
            oend_next = s1_end_reg;
            oerr_next = s1_err_reg;
            if (s1_err_reg)
            begin
                ob_next   = '0;
                ocnt_next = 3'd1;
            end
            else
            begin
                ob_next   = enc.bytes;
                ocnt_next = enc.count;
            end
        end
        else if (out_take)
        begin
            ob_next   = {8'b0, ob_reg[31:8]};
            ocnt_next = ocnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_encoding_reg <= ust_pkg::ENC_UTF8;
            target_encoding_reg <= ust_pkg::ENC_UTF8;
            replacement_reg     <= ust_pkg::REPLACEMENT_RESET;
            gb_reg              <= '{default: 8'h00};
            held_reg            <= 2'd0;
            glen_reg            <= 3'd0;
            s1_valid_reg        <= 1'b0;
            s1_err_reg          <= 1'b0;
            s1_end_reg          <= 1'b0;
            s1_g_reg            <= '0;
            s1_len_reg          <= 3'd0;
            ob_reg              <= '0;
            ocnt_reg            <= 3'd0;
            oend_reg            <= 1'b0;
            oerr_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ust_pkg::CFG_SOURCE_ENCODING:
                    begin
                        source_encoding_reg <= cfg_data[2:0];
                    end
                    ust_pkg::CFG_TARGET_ENCODING:
                    begin
                        target_encoding_reg <= cfg_data[2:0];
                    end
                    ust_pkg::CFG_REPLACEMENT_CODEPOINT:
                    begin
                        replacement_reg <= cfg_data[20:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            gb_reg       <= gb_next;
            held_reg     <= held_next;
            glen_reg     <= glen_next;
            s1_valid_reg <= s1_valid_next;
            s1_err_reg   <= s1_err_next;
            s1_end_reg   <= s1_end_next;
            s1_g_reg     <= s1_g_next;
            s1_len_reg   <= s1_len_next;
            ob_reg       <= ob_next;
            ocnt_reg     <= ocnt_next;
            oend_reg     <= oend_next;
            oerr_reg     <= oerr_next;
        end
    end

    assign m_axis_tvalid   = (ocnt_reg != 3'd0);
    assign m_axis_tdata    = ob_reg[7:0];
    assign m_axis_tlast    = (ocnt_reg == 3'd1);
    assign m_axis_tuser[0] = oend_reg && (ocnt_reg == 3'd1);
    assign m_axis_tuser[1] = oerr_reg;

endmodule

`default_nettype wire
